/* hdl/ffdc_pkg.sv */
// ffdc_pkg: shared types and constants for the flooding block with duplicate cache.
// Used by ffdc_ctrl, ffdc_dp and flood_forward_with_duplicate_cache_top.
package ffdc_pkg;

	localparam int CACHE_DEPTH_DEF = 32;
	localparam int IN_W            = 104;
	localparam int OUT_W           = 208;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 32;

	localparam logic [15:0] BCAST_ADDR = 16'hFFFF;

	localparam logic [7:0]  DEFAULT_TTL_RST  = 8'd5;
	localparam logic        DEDUP_EN_RST     = 1'b1;
	localparam logic [5:0]  MAX_ENTRIES_RST  = 6'd30;
	localparam logic [31:0] HOLD_TICKS_RST   = 32'd3000;
	localparam logic [15:0] NODE_ADDRESS_RST = 16'd0;

	typedef enum logic [1:0] {
		ACT_DOWN = 2'd0,
		ACT_UP   = 2'd1,
		ACT_DROP = 2'd2
	} act_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEFAULT_TTL  = 3'd0,
		CFG_DEDUP_ENABLE = 3'd1,
		CFG_MAX_ENTRIES  = 3'd2,
		CFG_HOLD_TICKS   = 3'd3,
		CFG_NODE_ADDRESS = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] src;
		logic [31:0] seq;
		logic [31:0] expiry;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_APPEND,
		ST_DECIDE,
		ST_LOAD0,
		ST_LOAD1
	} state_t;

	typedef struct packed {
		logic accept;
		logic scan_init;
		logic rd;
		logic chk;
		logic scan_end;
		logic append;
		logic decide;
		logic load0;
		logic load1;
	} cmd_t;

	typedef struct packed {
		logic left_zero;
		logic dedup;
		logic full;
		logic dup;
		logic chk_stop;
		logic out_free;
		logic two;
	} status_t;

endpackage

/* hdl/flood_forward_with_duplicate_cache_top.sv */
// flood_forward_with_duplicate_cache_top: flooding network layer with duplicate cache.
// Depends on ffdc_pkg, ffdc_ctrl and ffdc_dp.
//
// Input stream: one item per transfer, tuser = request kind (0 local send,
// 1 received header). Output stream: one or two results per item, tlast on
// the final one; each result carries the counters after the whole item.
// Configuration: cfg_wen/cfg_index/cfg_wdata; the user must write it only while idle, the block does not enforce this.
//
// Timing: a received header (cache enabled) reads and checks the live
// cache entries (up to 32 at depth 32) one at a time, a read then a check
// state for each, through the single cache read port; a duplicate found
// with nothing expired ahead of it ends the scan early. A local send with
// room in the cache goes to append, and with the cache disabled to the
// decision. The first result is loaded in the load state after decide,
// once the output register is free. Items are handled one at a time; the
// last result waits in the output register while the next item is taken.
// Reset clears the cache (empty), sequence number and all counters, and
// loads the register defaults. A stalled receiver holds the output register
// and the sequencer waits before loading the next result.
module flood_forward_with_duplicate_cache_top #(
	parameter int CACHE_DEPTH = ffdc_pkg::CACHE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// now_ticks[31:0], source_addr[47:32], dest_addr[63:48], seq_in[95:64], ttl_in[103:96]
	input  logic [ffdc_pkg::IN_W-1:0]        s_axis_tdata,
	// req_type[0]
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// action[1:0], out_source[17:2], out_dest[33:18], out_seq[65:34], out_ttl[73:66],
	// sent_total[105:74], received_total[137:106], forwarded_total[169:138],
	// hop_total[201:170], zero fill[207:202]
	output logic [ffdc_pkg::OUT_W-1:0]       m_axis_tdata,
	output logic                             m_axis_tlast,
	input  logic                             cfg_wen,
	input  logic [ffdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ffdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	ffdc_pkg::cmd_t    cmd;
	ffdc_pkg::status_t sts;

	ffdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_req   (s_axis_tuser),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (s_axis_tready)
	);

	ffdc_dp #(
		.CACHE_DEPTH (CACHE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata),
		.in_req    (s_axis_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

/* hdl/ffdc_ctrl.sv */
// ffdc_ctrl: sequencer for accept, cache scan, append, decision and result transfers.
// Depends on ffdc_pkg; drives ffdc_dp through cmd_t and reads status_t.
module ffdc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_req,
	input  ffdc_pkg::status_t sts,
	output ffdc_pkg::cmd_t    cmd,
	output logic              in_ready
);

	ffdc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffdc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ffdc_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (sts.dedup && (in_req || sts.full))
						state_d = ffdc_pkg::ST_SCAN_RD;
					else if (sts.dedup)
						state_d = ffdc_pkg::ST_APPEND;
					else
						state_d = ffdc_pkg::ST_DECIDE;
				end
			end
			ffdc_pkg::ST_SCAN_RD: begin
				if (sts.left_zero)
					state_d = sts.dup ? ffdc_pkg::ST_DECIDE : ffdc_pkg::ST_APPEND;
				else
					state_d = ffdc_pkg::ST_SCAN_CHK;
			end
			ffdc_pkg::ST_SCAN_CHK: begin
				// match with nothing removed ahead of it: rest of cache is already in place
				state_d = sts.chk_stop ? ffdc_pkg::ST_DECIDE : ffdc_pkg::ST_SCAN_RD;
			end
			ffdc_pkg::ST_APPEND: state_d = ffdc_pkg::ST_DECIDE;
			ffdc_pkg::ST_DECIDE: state_d = ffdc_pkg::ST_LOAD0;
			ffdc_pkg::ST_LOAD0: begin
				if (sts.out_free)
					state_d = sts.two ? ffdc_pkg::ST_LOAD1 : ffdc_pkg::ST_IDLE;
			end
			ffdc_pkg::ST_LOAD1: begin
				if (sts.out_free)
					state_d = ffdc_pkg::ST_IDLE;
			end
			default: state_d = ffdc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ffdc_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.accept    = in_valid;
				cmd.scan_init = in_valid;
			end
			ffdc_pkg::ST_SCAN_RD: begin
				cmd.scan_end = sts.left_zero;
				cmd.rd       = !sts.left_zero;
			end
			ffdc_pkg::ST_SCAN_CHK: cmd.chk = 1'b1;
			ffdc_pkg::ST_APPEND:   cmd.append = 1'b1;
			ffdc_pkg::ST_DECIDE:   cmd.decide = 1'b1;
			ffdc_pkg::ST_LOAD0:    cmd.load0 = sts.out_free;
			ffdc_pkg::ST_LOAD1:    cmd.load1 = sts.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* hdl/ffdc_dp.sv */
// ffdc_dp: configuration registers, ring-buffer duplicate cache, counters, result register.
// Depends on ffdc_pkg; sequenced by ffdc_ctrl.
module ffdc_dp #(
	parameter int CACHE_DEPTH = ffdc_pkg::CACHE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ffdc_pkg::cmd_t                   cmd,
	output ffdc_pkg::status_t                sts,
	input  logic [ffdc_pkg::IN_W-1:0]        in_data,
	input  logic                             in_req,
	input  logic                             cfg_wen,
	input  logic [ffdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ffdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ffdc_pkg::OUT_W-1:0]       out_data,
	output logic                             out_last
);

	localparam int PW = $clog2(CACHE_DEPTH);
	localparam int CW = $clog2(CACHE_DEPTH + 1);

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		ptr_inc = (p == PW'(CACHE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// configuration
	logic [7:0]  dttl_q;
	logic        dedup_q;
	logic [5:0]  maxent_q;
	logic [31:0] hold_q;
	logic [15:0] node_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dttl_q   <= ffdc_pkg::DEFAULT_TTL_RST;
			dedup_q  <= ffdc_pkg::DEDUP_EN_RST;
			maxent_q <= ffdc_pkg::MAX_ENTRIES_RST;
			hold_q   <= ffdc_pkg::HOLD_TICKS_RST;
			node_q   <= ffdc_pkg::NODE_ADDRESS_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				ffdc_pkg::CFG_DEFAULT_TTL:  dttl_q   <= cfg_wdata[7:0];
				ffdc_pkg::CFG_DEDUP_ENABLE: dedup_q  <= cfg_wdata[0];
				ffdc_pkg::CFG_MAX_ENTRIES:  maxent_q <= cfg_wdata[5:0];
				ffdc_pkg::CFG_HOLD_TICKS:   hold_q   <= cfg_wdata;
				ffdc_pkg::CFG_NODE_ADDRESS: node_q   <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	logic [CW-1:0] limit;
	always_comb begin
		if (maxent_q == 6'd0)
			limit = CW'(1);
		else if (int'(maxent_q) > CACHE_DEPTH)
			limit = CW'(CACHE_DEPTH);
		else
			limit = CW'(maxent_q);
	end

	// captured item
	logic        req_q;
	logic [31:0] now_q;
	logic [15:0] src_q;
	logic [15:0] dst_q;
	logic [31:0] seq_q;
	logic [7:0]  ttl_q;
	logic [31:0] next_seq_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= in_req;
			now_q <= in_data[31:0];
			src_q <= in_req ? in_data[47:32] : node_q;
			dst_q <= in_data[63:48];
			seq_q <= in_req ? in_data[95:64] : next_seq_q;
			ttl_q <= in_data[103:96];
		end
	end

	logic [32:0] exp_sum;
	logic [31:0] new_exp;
	assign exp_sum = {1'b0, now_q} + {1'b0, hold_q};
	assign new_exp = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];

	// cache storage: ring of entries starting at head_q
	ffdc_pkg::entry_t mem [CACHE_DEPTH];
	ffdc_pkg::entry_t rd_q;
	ffdc_pkg::entry_t wr_data;
	logic [PW-1:0]    wr_addr;
	logic             wr_en;

	logic [PW-1:0] head_q, tail_q, rp_q, wp_q;
	logic [CW-1:0] count_q, left_q;
	logic          copying_q, dup_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.rd)
			rd_q <= mem[rp_q];
	end

	logic expired, removing, is_match;
	assign expired  = rd_q.expiry < now_q;
	assign removing = !copying_q && expired;
	assign is_match = !copying_q && !expired && req_q &&
	                  rd_q.src == src_q && rd_q.seq == seq_q;

	logic evict;
	assign evict = count_q >= limit;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wp_q;
		wr_data = rd_q;
		if (cmd.chk && !removing) begin
			wr_en = (wp_q != rp_q) || is_match;
			if (is_match)
				wr_data = '{src: src_q, seq: seq_q, expiry: new_exp};
		end else if (cmd.append) begin
			wr_en   = 1'b1;
			wr_addr = tail_q;
			wr_data = '{src: src_q, seq: seq_q, expiry: new_exp};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			rp_q      <= '0;
			wp_q      <= '0;
			count_q   <= '0;
			left_q    <= '0;
			copying_q <= 1'b0;
			dup_q     <= 1'b0;
		end else begin
			if (cmd.scan_init) begin
				rp_q      <= head_q;
				wp_q      <= head_q;
				left_q    <= count_q;
				copying_q <= 1'b0;
				dup_q     <= 1'b0;
			end
			if (cmd.chk) begin
				rp_q   <= ptr_inc(rp_q);
				left_q <= left_q - 1'b1;
				if (removing) begin
					count_q <= count_q - 1'b1;
					// a local send removes only the first expired entry
					if (!req_q)
						copying_q <= 1'b1;
				end else begin
					wp_q <= ptr_inc(wp_q);
					if (is_match) begin
						dup_q     <= 1'b1;
						copying_q <= 1'b1;
					end
				end
			end
			if (cmd.scan_end)
				tail_q <= wp_q;
			if (cmd.append) begin
				tail_q <= ptr_inc(tail_q);
				if (evict)
					head_q <= ptr_inc(head_q);
				else
					count_q <= count_q + 1'b1;
			end
		end
	end

	// counters and result decision
	logic [31:0] sent_q, recv_q, fwd_q, hop_q;
	logic [1:0]  r0_act_q, r1_act_q;
	logic [7:0]  r0_ttl_q, r1_ttl_q;
	logic        two_q;

	logic [7:0]  ttl_dec;
	logic        ttl_gt1;
	logic [31:0] hop_base;
	assign ttl_dec  = ttl_q - 8'd1;
	assign ttl_gt1  = ttl_q > 8'd1;
	assign hop_base = hop_q + {24'd0, dttl_q} + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_seq_q <= '0;
			sent_q     <= '0;
			recv_q     <= '0;
			fwd_q      <= '0;
			hop_q      <= '0;
			two_q      <= 1'b0;
		end else begin
			if (cmd.accept && !in_req)
				next_seq_q <= next_seq_q + 32'd1;
			if (cmd.decide) begin
				two_q <= 1'b0;
				if (!req_q) begin
					sent_q <= sent_q + 32'd1;
				end else if (!dup_q) begin
					if (dst_q == node_q) begin
						hop_q  <= hop_base - {24'd0, ttl_q};
						recv_q <= recv_q + 32'd1;
					end else if (dst_q == ffdc_pkg::BCAST_ADDR) begin
						recv_q <= recv_q + 32'd1;
						if (ttl_gt1) begin
							fwd_q <= fwd_q + 32'd1;
							two_q <= 1'b1;
							hop_q <= hop_base - {24'd0, ttl_dec};
						end else begin
							hop_q <= hop_base - {24'd0, ttl_q};
						end
					end else if (ttl_gt1) begin
						fwd_q <= fwd_q + 32'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			r1_act_q <= ffdc_pkg::ACT_UP;
			r1_ttl_q <= ttl_dec;
			if (!req_q) begin
				r0_act_q <= ffdc_pkg::ACT_DOWN;
				r0_ttl_q <= dttl_q;
			end else if (dup_q) begin
				r0_act_q <= ffdc_pkg::ACT_DROP;
				r0_ttl_q <= ttl_q;
			end else if (dst_q == node_q) begin
				r0_act_q <= ffdc_pkg::ACT_UP;
				r0_ttl_q <= ttl_q;
			end else if (dst_q == ffdc_pkg::BCAST_ADDR) begin
				r0_act_q <= ttl_gt1 ? ffdc_pkg::ACT_DOWN : ffdc_pkg::ACT_UP;
				r0_ttl_q <= ttl_gt1 ? ttl_dec : ttl_q;
			end else begin
				r0_act_q <= ttl_gt1 ? ffdc_pkg::ACT_DOWN : ffdc_pkg::ACT_DROP;
				r0_ttl_q <= ttl_gt1 ? ttl_dec : ttl_q;
			end
		end
	end

	// result register
	logic                       out_valid_q, out_last_q;
	logic [ffdc_pkg::OUT_W-1:0] out_data_q;
	logic                       load;
	logic [1:0]                 ld_act;
	logic [7:0]                 ld_ttl;
	assign load   = cmd.load0 || cmd.load1;
	assign ld_act = cmd.load1 ? r1_act_q : r0_act_q;
	assign ld_ttl = cmd.load1 ? r1_ttl_q : r0_ttl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_last_q <= cmd.load1 || !two_q;
			out_data_q <= {6'd0, hop_q, fwd_q, recv_q, sent_q, ld_ttl, seq_q, dst_q, src_q,
			               ld_act};
		end
	end

	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;
	assign out_data  = out_data_q;

	assign sts.left_zero = left_q == '0;
	assign sts.dedup     = dedup_q;
	assign sts.full      = evict;
	assign sts.dup       = dup_q;
	assign sts.chk_stop  = is_match && (wp_q == rp_q);
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.two       = two_q;

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(CACHE_DEPTH))
		else $error("cache count above depth");
	assert property (@(posedge clk) disable iff (!arst_n) left_q <= count_q)
		else $error("scan remainder exceeds live entries");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.append |=> count_q != '0)
		else $error("cache empty after append");
	assert property (@(posedge clk) disable iff (!arst_n) load |-> sts.out_free)
		else $error("result register overwritten before transfer");

endmodule

/* sim/tb_flood_forward_with_duplicate_cache_top.sv */
// Testbench for flood_forward_with_duplicate_cache_top: an own flooding and duplicate-cache
// predictor checks every output transfer field by field. Depends on ffdc_pkg and the top.
module tb_flood_forward_with_duplicate_cache_top;
	import ffdc_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int DEPTH = 32;

	typedef struct {
		logic        req;
		logic [31:0] now;
		logic [15:0] src;
		logic [15:0] dst;
		logic [31:0] seq;
		logic [7:0]  ttl;
	} hdr_t;

	typedef struct {
		act_t        act;
		logic [15:0] src;
		logic [15:0] dst;
		logic [31:0] seq;
		logic [7:0]  ttl;
		logic        last;
		logic [31:0] sent;
		logic [31:0] rcvd;
		logic [31:0] fwd;
		logic [31:0] hops;
	} pkt_t;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	flood_forward_with_duplicate_cache_top dut (.*);

	// predictor state and register copies
	logic [15:0] c_src[DEPTH];
	logic [31:0] c_seq[DEPTH];
	logic [31:0] c_exp[DEPTH];
	int          c_cnt;
	logic [31:0] nseq, sent_cnt, rcvd_cnt, fwd_cnt, hop_sum;
	logic [7:0]  r_ttl;
	logic        r_dedup;
	logic [5:0]  r_max;
	logic [31:0] r_hold;
	logic [15:0] r_node;

	hdr_t pend[$];
	pkt_t expq[$];
	hdr_t cur;
	int   errs = 0;
	int   cycles = 0;
	int   gap = 0;
	int   stall = 0;
	int   long_hold = 0;
	bit   quiet = 0;

	// stimulus helpers
	logic [31:0] tnow = 0;
	logic [31:0] lsends = 0;
	logic [15:0] hist_src[$];
	logic [31:0] hist_seq[$];

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic int cache_limit();
		if (r_max < 1) return 1;
		if (r_max > DEPTH) return DEPTH;
		return r_max;
	endfunction

	function automatic logic [31:0] expiry_at(logic [31:0] now);
		logic [32:0] e;
		e = {1'b0, now} + {1'b0, r_hold};
		return e[32] ? 32'hFFFF_FFFF : e[31:0];
	endfunction

	function automatic void drop_entry(int idx);
		if (idx >= c_cnt) return;
		for (int i = idx; i + 1 < c_cnt; i++) begin
			c_src[i] = c_src[i+1];
			c_seq[i] = c_seq[i+1];
			c_exp[i] = c_exp[i+1];
		end
		c_cnt--;
	endfunction

	function automatic void add_entry(logic [15:0] s, logic [31:0] q, logic [31:0] now);
		if (c_cnt >= cache_limit() && c_cnt > 0) drop_entry(0);
		if (c_cnt >= DEPTH) drop_entry(0);
		c_src[c_cnt] = s;
		c_seq[c_cnt] = q;
		c_exp[c_cnt] = expiry_at(now);
		c_cnt++;
	endfunction

	// works out the results of one accepted item and queues them
	function automatic void flood_predict(hdr_t h);
		pkt_t r[2];
		int   n;
		bit   dup;
		int   i;
		logic [7:0] t;
		n = 0;
		dup = 0;
		if (!h.req) begin
			if (r_dedup) begin
				if (c_cnt >= cache_limit())
					for (i = 0; i < c_cnt; i++)
						if (c_exp[i] < h.now) begin
							drop_entry(i);
							break;
						end
				add_entry(r_node, nseq, h.now);
			end
			r[0] = '{ACT_DOWN, r_node, h.dst, nseq, r_ttl, 0, 0, 0, 0, 0};
			n = 1;
			nseq++;
			sent_cnt++;
		end else begin
			if (r_dedup) begin
				i = 0;
				while (i < c_cnt) begin
					if (c_exp[i] < h.now) begin
						drop_entry(i);
						continue;
					end
					if (c_src[i] == h.src && c_seq[i] == h.seq) begin
						c_exp[i] = expiry_at(h.now);
						dup = 1;
						break;
					end
					i++;
				end
				if (!dup) add_entry(h.src, h.seq, h.now);
			end
			if (dup) begin
				r[0] = '{ACT_DROP, h.src, h.dst, h.seq, h.ttl, 0, 0, 0, 0, 0};
				n = 1;
			end else if (h.dst == r_node) begin
				hop_sum += 32'(r_ttl) + 1 - 32'(h.ttl);
				rcvd_cnt++;
				r[0] = '{ACT_UP, h.src, h.dst, h.seq, h.ttl, 0, 0, 0, 0, 0};
				n = 1;
			end else if (h.dst == BCAST_ADDR) begin
				t = h.ttl;
				if (t > 1) begin
					t--;
					fwd_cnt++;
					r[0] = '{ACT_DOWN, h.src, h.dst, h.seq, t, 0, 0, 0, 0, 0};
					n = 1;
				end
				hop_sum += 32'(r_ttl) + 1 - 32'(t);
				rcvd_cnt++;
				r[n] = '{ACT_UP, h.src, h.dst, h.seq, t, 0, 0, 0, 0, 0};
				n++;
			end else if (h.ttl > 1) begin
				fwd_cnt++;
				r[0] = '{ACT_DOWN, h.src, h.dst, h.seq, h.ttl - 8'd1, 0, 0, 0, 0, 0};
				n = 1;
			end else begin
				r[0] = '{ACT_DROP, h.src, h.dst, h.seq, h.ttl, 0, 0, 0, 0, 0};
				n = 1;
			end
		end
		for (int k = 0; k < n; k++) begin
			r[k].last = (k == n - 1);
			r[k].sent = sent_cnt;
			r[k].rcvd = rcvd_cnt;
			r[k].fwd  = fwd_cnt;
			r[k].hops = hop_sum;
			expq.insert(expq.size(), r[k]);
		end
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 0;
			gap = 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) flood_predict(cur);
			if (gap > 0) begin
				gap--;
				s_axis_tvalid <= 0;
			end else if (pend.size() > 0) begin
				cur = pend[0];
				pend.delete(0);
				s_axis_tdata <= {cur.ttl, cur.seq, cur.dst, cur.src, cur.now};
				s_axis_tuser <= cur.req;
				s_axis_tvalid <= 1;
				gap = quiet ? 0 : $urandom_range(0, 8);
			end else begin
				s_axis_tvalid <= 0;
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
			stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) stall = quiet ? 0 : $urandom_range(0, 8);
			if (long_hold > 0) begin
				long_hold--;
				m_axis_tready <= 0;
			end else if (stall > 0) begin
				stall--;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
			errs++;
		end
	endtask

	always @(posedge clk) begin
		pkt_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expq.size() == 0) begin
				$display("%0t unexpected transfer: expected none actual %h", $time, m_axis_tdata);
				errs++;
			end else begin
				e = expq[0];
				expq.delete(0);
				check_field("action", e.act, m_axis_tdata[1:0]);
				check_field("out_source", e.src, m_axis_tdata[17:2]);
				check_field("out_dest", e.dst, m_axis_tdata[33:18]);
				check_field("out_seq", e.seq, m_axis_tdata[65:34]);
				check_field("out_ttl", e.ttl, m_axis_tdata[73:66]);
				check_field("last", e.last, m_axis_tlast);
				check_field("sent_total", e.sent, m_axis_tdata[105:74]);
				check_field("received_total", e.rcvd, m_axis_tdata[137:106]);
				check_field("forwarded_total", e.fwd, m_axis_tdata[169:138]);
				check_field("hop_total", e.hops, m_axis_tdata[201:170]);
				check_field("fill", 0, m_axis_tdata[207:202]);
			end
		end
	end

	task automatic cfg_write(cfg_idx_t idx, logic [31:0] v);
		@(posedge clk);
		cfg_wen <= 1;
		cfg_index <= idx;
		cfg_wdata <= v;
		case (idx)
			CFG_DEFAULT_TTL:  r_ttl = v[7:0];
			CFG_DEDUP_ENABLE: r_dedup = v[0];
			CFG_MAX_ENTRIES:  r_max = v[5:0];
			CFG_HOLD_TICKS:   r_hold = v;
			CFG_NODE_ADDRESS: r_node = v[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wen <= 0;
	endtask

	task automatic set_regs(logic [7:0] ttl, logic en, logic [5:0] mx, logic [31:0] hold,
			logic [15:0] node);
		cfg_write(CFG_DEFAULT_TTL, ttl);
		cfg_write(CFG_DEDUP_ENABLE, en);
		cfg_write(CFG_MAX_ENTRIES, mx);
		cfg_write(CFG_HOLD_TICKS, hold);
		cfg_write(CFG_NODE_ADDRESS, node);
	endtask

	task automatic push_item(logic req, logic [15:0] src, logic [15:0] dst, logic [31:0] seq,
			logic [7:0] ttl, logic [31:0] dt);
		hdr_t h;
		logic [32:0] t;
		t = {1'b0, tnow} + dt;
		tnow = t[32] ? 32'hFFFF_FFFF : t[31:0];
		h = '{req, tnow, src, dst, seq, ttl};
		if (req) begin
			hist_src.insert(hist_src.size(), src);
			hist_seq.insert(hist_seq.size(), seq);
			if (hist_src.size() > 48) begin
				hist_src.delete(0);
				hist_seq.delete(0);
			end
		end else begin
			lsends++;
		end
		@(negedge clk);
		pend.insert(pend.size(), h);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pend.size() != 0 || s_axis_tvalid || expq.size() != 0);
		repeat (150) @(posedge clk);
	endtask

	task automatic random_items(int n);
		logic [15:0] src, dst;
		logic [31:0] seq, dt;
		logic [7:0]  ttl;
		int k, p;
		for (int j = 0; j < n; j++) begin
			p = $urandom_range(0, 99);
			dt = (r_hold > 64) ? $urandom_range(0, r_hold / 8 + 2) : $urandom_range(0, 4);
			if ($urandom_range(0, 19) == 0) dt = r_hold + 1 + $urandom_range(0, 3);
			if ($urandom_range(0, 2) == 0) dt = 0;
			case ($urandom_range(0, 3))
				0: dst = BCAST_ADDR;
				1: dst = r_node;
				2: dst = $urandom_range(0, 65535);
				default: dst = $urandom_range(0, 1) ? BCAST_ADDR : $urandom_range(0, 3);
			endcase
			ttl = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 3);
			if (p < 25) begin
				push_item(0, $urandom_range(0, 65534), dst, $urandom, $urandom, dt);
			end else if (p < 55 && hist_src.size() > 0) begin
				k = $urandom_range(0, hist_src.size() - 1);
				push_item(1, hist_src[k], dst, hist_seq[k], ttl, dt);
			end else if (p < 65 && lsends > 0) begin
				seq = lsends - 1 - $urandom_range(0, 3);
				push_item(1, r_node, dst, seq, ttl, dt);
			end else begin
				src = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65534) : $urandom_range(0, 5);
				seq = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40);
				push_item(1, src, dst, seq, ttl, dt);
			end
		end
	endtask

	initial begin
		r_ttl = DEFAULT_TTL_RST;
		r_dedup = DEDUP_EN_RST;
		r_max = MAX_ENTRIES_RST;
		r_hold = HOLD_TICKS_RST;
		r_node = NODE_ADDRESS_RST;
		c_cnt = 0;
		nseq = 0;
		sent_cnt = 0;
		rcvd_cnt = 0;
		fwd_cnt = 0;
		hop_sum = 0;
		cfg_wen = 0;
		cfg_index = '0;
		cfg_wdata = '0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed, with reset register values
		push_item(0, 16'h1234, BCAST_ADDR, 0, 0, 0);
		push_item(1, 0, BCAST_ADDR, 0, 8'd3, 1);           // own send echoed back
		push_item(1, 16'd65534, BCAST_ADDR, 32'hFFFF_FFFF, 8'd255, 1);
		push_item(1, 16'd65534, BCAST_ADDR, 32'hFFFF_FFFF, 8'd255, 1); // duplicate
		push_item(1, 7, BCAST_ADDR, 1, 8'd1, 0);
		push_item(1, 7, BCAST_ADDR, 2, 8'd0, 0);
		push_item(1, 7, BCAST_ADDR, 3, 8'd2, 0);
		push_item(1, 8, 16'd0, 4, 8'd0, 0);                // to this node
		push_item(1, 8, 16'd0, 5, 8'd255, 0);
		push_item(1, 9, 16'd65534, 6, 8'd1, 0);            // unicast, dropped
		push_item(1, 9, 16'd77, 7, 8'd2, 0);               // unicast, forwarded
		push_item(1, 9, 16'd77, 7, 8'd2, 3000);            // dup at exact expiry
		push_item(1, 9, 16'd77, 7, 8'd2, 3001);            // expired, new again
		push_item(0, 0, 16'd0, 0, 0, 0);
		push_item(0, 0, 16'hFFFF, 0, 0, 2);
		push_item(1, 16'hAAAA, 16'h5555, 32'hAAAA_5555, 8'hAA, 0);
		push_item(1, 16'h5555, 16'hAAAA, 32'h5555_AAAA, 8'h55, 0);
		wait_idle();

		set_regs(8'd255, 1, 6'd1, 32'd0, 16'd65534);
		push_item(1, 1, 16'd65534, 10, 8'd1, 1);
		push_item(1, 1, 16'd65534, 10, 8'd1, 0);           // dup, hold of zero
		push_item(1, 2, BCAST_ADDR, 11, 8'd9, 0);          // evicts the only entry
		push_item(1, 1, 16'd65534, 10, 8'd1, 0);
		random_items(110);
		wait_idle();

		quiet = 1;
		set_regs(8'd1, 1, 6'd32, 32'd50, 16'd1234);
		random_items(110);
		wait_idle();
		quiet = 0;

		set_regs(8'd128, 0, 6'd63, 32'd3000, 16'd3);
		random_items(100);
		wait_idle();

		set_regs(8'd5, 1, 6'd0, 32'd20, 16'd2);
		random_items(90);
		wait_idle();

		// fill a large cache, then shrink the limit below the live count
		set_regs(8'd7, 1, 6'd32, 32'd100000, 16'd4);
		for (int j = 0; j < 34; j++) push_item(1, 16'(j), BCAST_ADDR, 32'(j), 8'd4, 1);
		wait_idle();
		cfg_write(CFG_MAX_ENTRIES, 6'd3);
		@(negedge clk);
		long_hold = 400;
		random_items(110);
		wait_idle();

		// saturated expiry near the end of time
		set_regs(8'd200, 1, 6'd8, 32'hFFFF_FFFF, 16'd65535);
		push_item(1, 5, BCAST_ADDR, 5, 8'd6, 32'hFFFF_F000 - tnow);
		push_item(1, 5, BCAST_ADDR, 5, 8'd6, 32'h100);
		random_items(90);
		push_item(1, 6, 16'd12, 6, 8'd3, 32'hFFFF_FFFF);
		push_item(1, 6, 16'd12, 6, 8'd3, 0);
		wait_idle();

		if (errs == 0 && expq.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

/* sim.f */
hdl/ffdc_pkg.sv
hdl/ffdc_ctrl.sv
hdl/ffdc_dp.sv
hdl/flood_forward_with_duplicate_cache_top.sv
sim/tb_flood_forward_with_duplicate_cache_top.sv
